### hdl/ckmb_pkg.sv
// ----------------------------------------------------------------------------
// ckmb_pkg: shared types and constants for the chroma key matte blender
// Holds the pixel and configuration types, register indexes and the
// full-scale constant used by the matte and mix stages.
// ----------------------------------------------------------------------------
package ckmb_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned NumChan   = 3;
  localparam int unsigned SelW      = 2;
  localparam int unsigned SumW      = 2 * ChanW;
  localparam logic [ChanW-1:0] FullScale = 8'd255;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_KEY_CHANNEL  = 2'd0,
    REG_COMPARE_ONE  = 2'd1,
    REG_COMPARE_TWO  = 2'd2,
    REG_INVERT_MATTE = 2'd3
  } reg_idx_e;

  typedef logic [ChanW-1:0] chan_t;
  typedef chan_t [NumChan-1:0] px_t;

  typedef struct packed {
    logic [SelW-1:0] key_sel;
    logic [SelW-1:0] cmp1_sel;
    logic [SelW-1:0] cmp2_sel;
    logic            invert;
  } cfg_t;

  localparam cfg_t CfgReset = '{key_sel: 2'd1, cmp1_sel: 2'd0, cmp2_sel: 2'd2, invert: 1'b0};

  // channel pick, selector three reads as zero
  function automatic chan_t pick_chan(px_t px, logic [SelW-1:0] sel);
    chan_t res;
    case (sel)
      2'd0:    res = px[0];
      2'd1:    res = px[1];
      2'd2:    res = px[2];
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

### hdl/ckmb_matte.sv
// ----------------------------------------------------------------------------
// ckmb_matte: difference matte stage
// Key channel minus the larger compare channel, clamped at zero, optionally
// inverted; forced to zero outside the overlay region. Result is registered.
// ----------------------------------------------------------------------------
module ckmb_matte (
  input  logic                clk_i,
  input  logic                en_i,
  input  ckmb_pkg::cfg_t      cfg_i,
  input  ckmb_pkg::px_t       fg_i,
  input  logic                ovl_i,
  output ckmb_pkg::chan_t     matte_o
);

  ckmb_pkg::chan_t key, c1, c2, top, diff;
  ckmb_pkg::chan_t matte_d, matte_q;

  // channel selection and clamped difference
  always_comb begin
    key  = ckmb_pkg::pick_chan(fg_i, cfg_i.key_sel);
    c1   = ckmb_pkg::pick_chan(fg_i, cfg_i.cmp1_sel);
    c2   = ckmb_pkg::pick_chan(fg_i, cfg_i.cmp2_sel);
    top  = (c1 > c2) ? c1 : c2;
    diff = (key > top) ? (key - top) : '0;
    if (cfg_i.invert) begin
      diff = ckmb_pkg::FullScale - diff;
    end
    // zero weight passes the background through exactly
    matte_d = ovl_i ? diff : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      matte_q <= matte_d;
    end
  end

  assign matte_o = matte_q;

endmodule

### hdl/ckmb_mix.sv
// ----------------------------------------------------------------------------
// ckmb_mix: one channel of the alpha blend
// Stage A forms fg*m + bg*(255-m); stage B divides by 255 through the
// reciprocal identity floor(x/255) = (x + (x>>8) + 1) >> 8 for x < 65535.
// ----------------------------------------------------------------------------
module ckmb_mix (
  input  logic            clk_i,
  input  logic            en_a_i,
  input  logic            en_b_i,
  input  ckmb_pkg::chan_t fg_i,
  input  ckmb_pkg::chan_t bg_i,
  input  ckmb_pkg::chan_t matte_i,
  output ckmb_pkg::chan_t chan_o
);

  logic [ckmb_pkg::SumW-1:0] prod_fg, prod_bg;
  logic [ckmb_pkg::SumW-1:0] sum_d, sum_q;
  logic [ckmb_pkg::SumW:0]   quo_tmp;
  ckmb_pkg::chan_t           chan_d, chan_q;
  ckmb_pkg::chan_t           inv_m;

  // weighted sum, at most 255*255 so it fits 16 bits
  always_comb begin
    inv_m   = ckmb_pkg::FullScale - matte_i;
    prod_fg = {{ckmb_pkg::ChanW{1'b0}}, fg_i} * {{ckmb_pkg::ChanW{1'b0}}, matte_i};
    prod_bg = {{ckmb_pkg::ChanW{1'b0}}, bg_i} * {{ckmb_pkg::ChanW{1'b0}}, inv_m};
    sum_d   = prod_fg + prod_bg;
  end

  // divide by 255 with shift and add
  always_comb begin
    quo_tmp = {1'b0, sum_q} + {9'd0, sum_q[ckmb_pkg::SumW-1:ckmb_pkg::ChanW]}
              + {{ckmb_pkg::SumW{1'b0}}, 1'b1};
    chan_d  = quo_tmp[ckmb_pkg::SumW-1:ckmb_pkg::ChanW];
  end

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      sum_q <= sum_d;
    end
    if (en_b_i) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

### hdl/chroma_key_matte_blend.sv
// ----------------------------------------------------------------------------
// chroma_key_matte_blend: difference matte and alpha blend, one pixel a clock unless stalled
// Keys a foreground pixel against its own channels and blends it over the
// background pixel with an exact divide-by-255.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i/in_ready_o carry one pixel request (fg, bg and
//   the overlay flag). Output channel: out_valid_o/out_ready_i carry the
//   blended channels and the matte weight used.
//   Three register stages: matte stage, multiply and add stage, divide-by-255
//   stage. A request moves through them in that order and out_valid_o rises
//   when it reaches the last. Throughput is one pixel per cycle while out_ready_i is high;
//   each stage holds one request and advances when the stage after it is
//   empty or moving.
//   When out_ready_i is low the stages fill up and in_ready_o drops once all
//   three hold a request; nothing is dropped or repeated.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user
//   must write it only while the pipeline is empty, the block does not enforce it.
//   Reset empties the pipeline and loads the default selectors: key on
//   channel 1, compare against channels 0 and 2, no inversion.
//   Pixels outside the overlay pass the background with a matte of zero.
// ----------------------------------------------------------------------------
module chroma_key_matte_blend (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [1:0]  cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  fg_ch0_i,
  input  logic [7:0]  fg_ch1_i,
  input  logic [7:0]  fg_ch2_i,
  input  logic [7:0]  bg_ch0_i,
  input  logic [7:0]  bg_ch1_i,
  input  logic [7:0]  bg_ch2_i,
  input  logic        in_overlay_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_ch0_o,
  output logic [7:0]  out_ch1_o,
  output logic [7:0]  out_ch2_o,
  output logic [7:0]  matte_value_o
);

  ckmb_pkg::cfg_t cfg_q, cfg_d;
  logic v1_q, v2_q, v3_q;
  logic ov1_q, ov2_q, ov3_q;
  logic en1, en2, en3;
  ckmb_pkg::px_t fg_in, bg_in;
  ckmb_pkg::px_t fg1_q, bg1_q;
  ckmb_pkg::chan_t m1, m2_q, m3_q;
  ckmb_pkg::px_t out_px;

  // configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ckmb_pkg::reg_idx_e'(cfg_idx_i))
        ckmb_pkg::REG_KEY_CHANNEL:  cfg_d.key_sel  = cfg_wdata_i;
        ckmb_pkg::REG_COMPARE_ONE:  cfg_d.cmp1_sel = cfg_wdata_i;
        ckmb_pkg::REG_COMPARE_TWO:  cfg_d.cmp2_sel = cfg_wdata_i;
        ckmb_pkg::REG_INVERT_MATTE: cfg_d.invert   = cfg_wdata_i[0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ckmb_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // stage enables, a stage loads when it is empty or its request moves on
  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  assign fg_in = {fg_ch2_i, fg_ch1_i, fg_ch0_i};
  assign bg_in = {bg_ch2_i, bg_ch1_i, bg_ch0_i};

  // stage payloads: pixel and overlay flag in stage 1, matte and overlay flag in stages 2 and 3
  always_ff @(posedge clk_i) begin
    if (en1) begin
      fg1_q <= fg_in;
      bg1_q <= bg_in;
      ov1_q <= in_overlay_i;
    end
    if (en2) begin
      m2_q  <= m1;
      ov2_q <= ov1_q;
    end
    if (en3) begin
      m3_q  <= m2_q;
      ov3_q <= ov2_q;
    end
  end

  ckmb_matte u_matte (
    .clk_i   (clk_i),
    .en_i    (en1),
    .cfg_i   (cfg_q),
    .fg_i    (fg_in),
    .ovl_i   (in_overlay_i),
    .matte_o (m1)
  );

  // per-channel blend lanes
  for (genvar c = 0; c < ckmb_pkg::NumChan; c++) begin : g_lane
    ckmb_mix u_mix (
      .clk_i   (clk_i),
      .en_a_i  (en2),
      .en_b_i  (en3),
      .fg_i    (fg1_q[c]),
      .bg_i    (bg1_q[c]),
      .matte_i (m1),
      .chan_o  (out_px[c])
    );
  end

  assign out_valid_o   = v3_q;
  assign out_ch0_o     = out_px[0];
  assign out_ch1_o     = out_px[1];
  assign out_ch2_o     = out_px[2];
  assign matte_value_o = m3_q;

  // a pixel outside the overlay reports a zero matte
  a_bypass_matte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !ov3_q) |-> (matte_value_o == '0))
    else $error("matte nonzero outside overlay");

  // input only stalls when every stage holds a request and output is blocked
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && !out_ready_i))
    else $error("input stalled with an empty stage");

  // an accepted request lands in stage 1
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted request not captured");

  // a full matte gives the foreground back unchanged in channel 0,
  // checked for a request that moved into stage 2 on the previous edge
  a_full_matte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && en3 && $past(en2) && m2_q == ckmb_pkg::FullScale)
    |=> (out_ch0_o == $past(fg1_q[0], 2)))
    else $error("full matte does not return foreground");

endmodule
